>>> design/f16fr_pkg.sv
// ----------------------------------------------------------------------------
// f16fr_pkg
// Shared types, codes and helpers for the Fletcher-16 frame receiver.
// ----------------------------------------------------------------------------
package f16fr_pkg;

  localparam int FRAME_LEN  = 9;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 4;
  localparam int WORD_W     = 32;
  localparam int CSUM_W     = 16;
  // running sums never exceed 0xff + 7*255 and 0xff + 35*255 in one frame
  localparam int SUM_LOW_W  = 11;
  localparam int SUM_HIGH_W = 14;

  localparam logic [BYTE_W-1:0] TYPE_BYTE_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] SUM_INIT        = 8'hff;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_GOOD = 2'd0;
  localparam status_t STATUS_BAD  = 2'd1;
  localparam status_t STATUS_DROP = 2'd2;

  typedef logic [POS_W-1:0] pos_t;
  localparam pos_t POS_TYPE     = 4'd0;
  localparam pos_t POS_ANCHOR_N = 4'd1;
  localparam pos_t POS_ANCHOR_R = 4'd2;
  localparam pos_t POS_WORD0    = 4'd3;
  localparam pos_t POS_WORD1    = 4'd4;
  localparam pos_t POS_WORD2    = 4'd5;
  localparam pos_t POS_WORD3    = 4'd6;
  localparam pos_t POS_CHECK_HI = 4'd7;
  localparam pos_t POS_CHECK_LO = 4'd8;

  // end-around reduction modulo 255, applied twice
  function automatic logic [BYTE_W-1:0] fold255(input logic [15:0] s);
    logic [8:0] t1;
    logic [8:0] t2;
    t1 = {1'b0, s[7:0]} + {1'b0, s[15:8]};
    t2 = {1'b0, t1[7:0]} + {8'd0, t1[8]};
    return t2[7:0];
  endfunction

endpackage

>>> design/f16fr_if.sv
// ----------------------------------------------------------------------------
// f16fr channel interfaces
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface f16fr_byte_if;
  logic                        valid;
  logic                        ready;
  logic [f16fr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface f16fr_result_if;
  logic                         valid;
  logic                         ready;
  f16fr_pkg::status_t           status;
  logic [f16fr_pkg::BYTE_W-1:0] anchor_number;
  logic [f16fr_pkg::BYTE_W-1:0] anchor_reference;
  logic [f16fr_pkg::WORD_W-1:0] distance_bits;
  logic [f16fr_pkg::CSUM_W-1:0] expected_checksum;
  logic [f16fr_pkg::CSUM_W-1:0] received_checksum;
  logic [f16fr_pkg::BYTE_W-1:0] dropped_byte;

  modport source (output valid, output status, output anchor_number,
                  output anchor_reference, output distance_bits,
                  output expected_checksum, output received_checksum,
                  output dropped_byte, input ready);
  modport sink   (input valid, input status, input anchor_number,
                  input anchor_reference, input distance_bits,
                  input expected_checksum, input received_checksum,
                  input dropped_byte, output ready);
endinterface

>>> design/fletcher16_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// fletcher16_frame_receiver_top
// Assembles 9-byte frames from received bytes and checks their Fletcher-16.
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                                    | request
//  ----------+-----+--------------------------------------------+-------------
//  rx_chan   | in  | rx_byte                                    | one byte
//  result    | out | status, anchors, distance, checksums, drop | one report
//  cfg_wr_*  | in  | frame_type_byte                            | none
//
//  one byte accepted per cycle while rx_chan is ready; a report appears in the
//  cycle after the byte that completes a frame or is dropped as a bad type byte
//  the only limit on rate is the single result register: rx_chan stalls
//  only while a report sits unclaimed in it
//  rst is synchronous; it clears the frame position and the result valid,
//  sets the sums to 0xff, and returns the type byte to 0xaa
//
module fletcher16_frame_receiver_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [f16fr_pkg::BYTE_W-1:0]  cfg_wr_data,
  f16fr_byte_if.sink                    rx_chan,
  f16fr_result_if.source                result
);
  import f16fr_pkg::*;

  // configuration
  logic [BYTE_W-1:0]     frame_type_byte;

  // frame assembly state
  pos_t                  byte_position;
  pos_t                  byte_position_next;
  logic [SUM_LOW_W-1:0]  sum_low;
  logic [SUM_LOW_W-1:0]  sum_low_next;
  logic [SUM_HIGH_W-1:0] sum_high;
  logic [SUM_HIGH_W-1:0] sum_high_next;
  logic [BYTE_W-1:0]     anchor_n_reg;
  logic [BYTE_W-1:0]     anchor_n_reg_next;
  logic [BYTE_W-1:0]     anchor_r_reg;
  logic [BYTE_W-1:0]     anchor_r_reg_next;
  logic [WORD_W-1:0]     payload_word;
  logic [WORD_W-1:0]     payload_word_next;
  logic [BYTE_W-1:0]     check_high_byte;
  logic [BYTE_W-1:0]     check_high_byte_next;

  // result register contents
  logic                  out_valid;
  status_t               out_status;
  logic [BYTE_W-1:0]     out_anchor_n;
  logic [BYTE_W-1:0]     out_anchor_r;
  logic [WORD_W-1:0]     out_distance;
  logic [CSUM_W-1:0]     out_expect;
  logic [CSUM_W-1:0]     out_recv;
  logic [BYTE_W-1:0]     out_dropped;

  logic                  load_result;
  status_t               res_status;
  logic [BYTE_W-1:0]     res_anchor_n;
  logic [BYTE_W-1:0]     res_anchor_r;
  logic [WORD_W-1:0]     res_distance;
  logic [CSUM_W-1:0]     res_expect;
  logic [CSUM_W-1:0]     res_recv;
  logic [BYTE_W-1:0]     res_dropped;

  logic                  in_fire;
  logic [BYTE_W-1:0]     b;
  logic [SUM_LOW_W-1:0]  add_low;
  logic [SUM_HIGH_W-1:0] add_high;
  logic [CSUM_W-1:0]     expect_sum;
  logic [CSUM_W-1:0]     recv_sum;

  // a new byte may enter while the result register is empty or being drained
  assign rx_chan.ready = !out_valid || result.ready;
  assign in_fire       = rx_chan.valid && rx_chan.ready;
  assign b             = rx_chan.rx_byte;

  // fletcher step on the stored sums
  assign add_low  = sum_low + {{(SUM_LOW_W-BYTE_W){1'b0}}, b};
  assign add_high = sum_high + {{(SUM_HIGH_W-SUM_LOW_W){1'b0}}, add_low};

  // sums are final once byte 6 has gone in; sum2 high, sum1 low
  assign expect_sum = {fold255({{(16-SUM_HIGH_W){1'b0}}, sum_high}),
                       fold255({{(16-SUM_LOW_W){1'b0}}, sum_low})};
  assign recv_sum   = {check_high_byte, b};

  always_comb begin
    byte_position_next   = byte_position;
    sum_low_next         = sum_low;
    sum_high_next        = sum_high;
    anchor_n_reg_next    = anchor_n_reg;
    anchor_r_reg_next    = anchor_r_reg;
    payload_word_next    = payload_word;
    check_high_byte_next = check_high_byte;
    load_result          = 1'b0;
    res_status           = STATUS_GOOD;
    res_anchor_n         = '0;
    res_anchor_r         = '0;
    res_distance         = '0;
    res_expect           = '0;
    res_recv             = '0;
    res_dropped          = '0;
    if (in_fire) begin
      unique case (byte_position)
        POS_ANCHOR_N: begin
          anchor_n_reg_next  = b;
          sum_low_next       = add_low;
          sum_high_next      = add_high;
          byte_position_next = POS_ANCHOR_R;
        end
        POS_ANCHOR_R: begin
          anchor_r_reg_next  = b;
          sum_low_next       = add_low;
          sum_high_next      = add_high;
          byte_position_next = POS_WORD0;
        end
        POS_WORD0, POS_WORD1, POS_WORD2, POS_WORD3: begin
          // big-endian: shift the word up one byte at a time
          payload_word_next  = {payload_word[WORD_W-BYTE_W-1:0], b};
          sum_low_next       = add_low;
          sum_high_next      = add_high;
          byte_position_next = byte_position + pos_t'(1);
        end
        POS_CHECK_HI: begin
          check_high_byte_next = b;
          byte_position_next   = POS_CHECK_LO;
        end
        POS_CHECK_LO: begin
          // frame complete: report it, good or not
          load_result        = 1'b1;
          res_status         = (expect_sum == recv_sum) ? STATUS_GOOD : STATUS_BAD;
          res_anchor_n       = anchor_n_reg;
          res_anchor_r       = anchor_r_reg;
          res_distance       = payload_word;
          res_expect         = expect_sum;
          res_recv           = recv_sum;
          byte_position_next = POS_TYPE;
        end
        default: begin
          // type byte, also the landing place for any position out of range
          byte_position_next = POS_TYPE;
          if (b != frame_type_byte) begin
            load_result = 1'b1;
            res_status  = STATUS_DROP;
            res_dropped = b;
          end else begin
            sum_low_next       = {{(SUM_LOW_W-BYTE_W){1'b0}}, SUM_INIT}
                                 + {{(SUM_LOW_W-BYTE_W){1'b0}}, b};
            sum_high_next      = {{(SUM_HIGH_W-BYTE_W){1'b0}}, SUM_INIT}
                                 + {{(SUM_HIGH_W-SUM_LOW_W){1'b0}}, sum_low_next};
            byte_position_next = POS_ANCHOR_N;
          end
        end
      endcase
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_type_byte <= TYPE_BYTE_RESET;
    end else if (cfg_wr_en) begin
      frame_type_byte <= cfg_wr_data;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_TYPE;
      sum_low         <= {{(SUM_LOW_W-BYTE_W){1'b0}}, SUM_INIT};
      sum_high        <= {{(SUM_HIGH_W-BYTE_W){1'b0}}, SUM_INIT};
      anchor_n_reg    <= '0;
      anchor_r_reg    <= '0;
      payload_word    <= '0;
      check_high_byte <= '0;
    end else begin
      byte_position   <= byte_position_next;
      sum_low         <= sum_low_next;
      sum_high        <= sum_high_next;
      anchor_n_reg    <= anchor_n_reg_next;
      anchor_r_reg    <= anchor_r_reg_next;
      payload_word    <= payload_word_next;
      check_high_byte <= check_high_byte_next;
    end
  end

  // result register: valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      out_status   <= res_status;
      out_anchor_n <= res_anchor_n;
      out_anchor_r <= res_anchor_r;
      out_distance <= res_distance;
      out_expect   <= res_expect;
      out_recv     <= res_recv;
      out_dropped  <= res_dropped;
    end
  end

  assign result.valid             = out_valid;
  assign result.status            = out_status;
  assign result.anchor_number     = out_anchor_n;
  assign result.anchor_reference  = out_anchor_r;
  assign result.distance_bits     = out_distance;
  assign result.expected_checksum = out_expect;
  assign result.received_checksum = out_recv;
  assign result.dropped_byte      = out_dropped;

`ifndef SYNTHESIS
  // position never leaves the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_CHECK_LO)
    else $error("frame position out of range");

  // a mid-frame byte never produces a report
  a_mid_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_fire && byte_position != POS_TYPE && byte_position != POS_CHECK_LO)
    |=> !result.valid)
    else $error("report raised on a mid-frame byte");

  // a matching type byte opens a frame
  a_frame_open: assert property (@(posedge clk) disable iff (rst)
    (in_fire && byte_position == POS_TYPE && b == frame_type_byte)
    |=> byte_position == POS_ANCHOR_N)
    else $error("type byte did not open a frame");

  // a good report carries equal checksums
  a_good_match: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_GOOD)
    |-> result.expected_checksum == result.received_checksum)
    else $error("good status with mismatching checksums");

  // a drop report carries only the dropped byte
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_DROP)
    |-> (result.anchor_number == '0 && result.distance_bits == '0
         && result.expected_checksum == '0 && result.received_checksum == '0))
    else $error("drop report carries frame fields");
`endif

endmodule
